// ===== hw/rtl/spq_pkg.sv =====
// shared constants, codes and control types for the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic    latch_req;
		status_t status_val;
		logic    rd_top;
		logic    rd_next;
		logic    wr_shift;
		logic    wr_key;
		logic    idx_dec;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    capture_removed;
		logic    load_out;
	} cmd_t;

	// conditions reported back to the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic gt;
		logic idx_one;
	} dp_stat_t;

endpackage

// ===== hw/rtl/spq_req_if.sv =====
// request channel of the sorted priority queue
`timescale 1ns / 1ps
interface spq_req_if;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [spq_pkg::DATA_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== hw/rtl/spq_rsp_if.sv =====
// result channel of the sorted priority queue
`timescale 1ns / 1ps
interface spq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [spq_pkg::DATA_W-1:0] removed_value;
	logic [1:0]                 status;
	logic [spq_pkg::CNT_W-1:0]  entry_count;
	logic                       is_empty;

	modport source (output valid, output removed_value, output status,
		output entry_count, output is_empty, input ready);
	modport sink   (input valid, input removed_value, input status,
		input entry_count, input is_empty, output ready);
endinterface

// ===== hw/rtl/spq_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// controller state machine for the sorted priority queue
`timescale 1ns / 1ps
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_opcode,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  spq_pkg::dp_stat_t stat,
	output spq_pkg::cmd_t     cmd
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SHIFT = 5'b00010,
		S_PLACE = 5'b00100,
		S_TAKE  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd            = '0;
		cmd.status_val = spq_pkg::ST_OK;
		state_d        = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					if (req_opcode == spq_pkg::OP_INSERT) begin
						if (stat.full) begin
							cmd.status_val = spq_pkg::ST_FULL;
							state_d        = S_DONE;
						end else if (stat.empty) begin
							state_d = S_PLACE;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_SHIFT;
						end
					end else begin
						if (stat.empty) begin
							cmd.status_val = spq_pkg::ST_EMPTY;
							state_d        = S_DONE;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_TAKE;
						end
					end
				end
			end
			S_SHIFT: begin
				if (stat.gt) begin
					// larger entry moves up one slot, look at the one below
					cmd.wr_shift = 1'b1;
					cmd.idx_dec  = 1'b1;
					if (stat.idx_one) begin
						state_d = S_PLACE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end else begin
					cmd.wr_key  = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_PLACE: begin
				cmd.wr_key  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_TAKE: begin
				cmd.capture_removed = 1'b1;
				cmd.cnt_dec         = 1'b1;
				state_d             = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != S_IDLE))
		else $error("request accepted but controller stayed idle");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten before it was taken");
`endif
endmodule

// ===== hw/rtl/spq_datapath.sv =====
// datapath of the sorted priority queue: entry store, count, compare and result register
`timescale 1ns / 1ps
module spq_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::cmd_t               cmd,
	output spq_pkg::dp_stat_t           stat,
	input  logic [spq_pkg::DATA_W-1:0]  req_value,
	output logic [spq_pkg::DATA_W-1:0]  removed_value,
	output logic [1:0]                  status,
	output logic [spq_pkg::CNT_W-1:0]   entry_count,
	output logic                        is_empty
);
	logic [spq_pkg::CNT_W-1:0]       count_q;
	logic [spq_pkg::VALUE_WIDTH-1:0] key_q;
	logic [spq_pkg::ADDR_W-1:0]      idx_q;
	logic [spq_pkg::DATA_W-1:0]      removed_q;
	spq_pkg::status_t                status_q;

	logic [spq_pkg::DATA_W-1:0]      out_removed_q;
	logic [1:0]                      out_status_q;
	logic [spq_pkg::CNT_W-1:0]       out_count_q;
	logic                            out_empty_q;

	logic                            wr_en;
	logic [spq_pkg::ADDR_W-1:0]      wr_addr;
	logic [spq_pkg::VALUE_WIDTH-1:0] wr_data;
	logic                            rd_en;
	logic [spq_pkg::ADDR_W-1:0]      rd_addr;
	logic [spq_pkg::VALUE_WIDTH-1:0] rd_data;
	logic [spq_pkg::CNT_W-1:0]       top_idx;
	logic [spq_pkg::ADDR_W-1:0]      next_idx;

	// slot count-1 holds the largest entry, the store is ascending
	assign top_idx  = count_q - spq_pkg::CNT_W'(1);
	assign next_idx = idx_q - spq_pkg::ADDR_W'(2);

	assign rd_en   = cmd.rd_top || cmd.rd_next;
	assign rd_addr = cmd.rd_top ? top_idx[spq_pkg::ADDR_W-1:0] : next_idx;
	assign wr_en   = cmd.wr_shift || cmd.wr_key;
	assign wr_addr = idx_q;
	assign wr_data = cmd.wr_shift ? rd_data : key_q;

	spq_ram #(
		.WIDTH(spq_pkg::VALUE_WIDTH),
		.DEPTH(spq_pkg::QUEUE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign stat.full    = (count_q == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
	assign stat.empty   = (count_q == '0);
	assign stat.gt      = ($signed(rd_data) > $signed(key_q));
	assign stat.idx_one = (idx_q == spq_pkg::ADDR_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + spq_pkg::CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - spq_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			key_q     <= spq_pkg::VALUE_WIDTH'($signed(req_value));
			idx_q     <= count_q[spq_pkg::ADDR_W-1:0];
			status_q  <= cmd.status_val;
			removed_q <= '0;
		end else begin
			if (cmd.idx_dec) begin
				idx_q <= idx_q - spq_pkg::ADDR_W'(1);
			end
			if (cmd.capture_removed) begin
				removed_q <= spq_pkg::DATA_W'($signed(rd_data));
			end
		end
		if (cmd.load_out) begin
			out_removed_q <= removed_q;
			out_status_q  <= status_q;
			out_count_q   <= count_q;
			out_empty_q   <= (count_q == '0);
		end
	end

	assign removed_value = out_removed_q;
	assign status        = out_status_q;
	assign entry_count   = out_count_q;
	assign is_empty      = out_empty_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (count_q < spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH)))
		else $error("insert completed into a full queue");

	a_shift_above_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> (idx_q != '0))
		else $error("entry shifted into the bottom slot");
`endif
endmodule

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue: a max-priority queue of signed values kept in one RAM in ascending
// order. Each request is an insert (opcode 0) or a remove of the largest entry (opcode 1) and
// gives exactly one result with the removed value, a status, the entry count and an empty
// flag. One request is in work at a time. An insert moves every stored entry strictly greater
// than the new value up one slot before it writes the value, since each such entry is read and
// moved through the single read and write port of the store; a remove takes the top entry, and a
// remove from an empty queue or an insert into a full one changes nothing in the store. A result
// waits in an output register, so the next request is taken while it is still waiting.
`timescale 1ns / 1ps
module sorted_priority_queue_core (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	spq_pkg::cmd_t     cmd;
	spq_pkg::dp_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_opcode(req.opcode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_value    (req.value),
		.removed_value(rsp.removed_value),
		.status       (rsp.status),
		.entry_count  (rsp.entry_count),
		.is_empty     (rsp.is_empty)
	);
endmodule

// ===== tb/sorted_priority_queue_core_tb.sv =====
// self-checking regression bench for the sorted priority queue core
`timescale 1ns / 1ps
module sorted_priority_queue_core_tb;
	import spq_pkg::*;

	localparam int HOLD_OFF_CYCLES = 200;
	localparam int STALL_LIMIT     = 1500;
	localparam int RANDOM_ITEMS    = 630;
	localparam int PHASE_ITEMS     = 70;
	localparam int CALM_ITEMS      = 100;
	localparam int HOLD_OFF_AT     = 150;
	localparam int DRAIN_CYCLES    = 20;
	localparam int REPORT_LIMIT    = 10;
	localparam int DIRECTED_COUNT  = 25;

	typedef struct packed {
		logic [DATA_W-1:0] removed_value;
		status_t           status;
		logic [CNT_W-1:0]  entry_count;
		logic              is_empty;
	} queue_result_t;

	typedef struct packed {
		opcode_t           op;
		logic [DATA_W-1:0] value;
		logic              typed;
		queue_result_t     result;
	} directed_row_t;

	// rows with typed set carry their own result, the rest go through the mirror
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0, 1'b1}},
		'{OP_REMOVE, 32'hffff_ffff, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0, 1'b1}},
		'{OP_INSERT, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, ST_OK,    7'd1, 1'b0}},
		'{OP_INSERT, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,    7'd2, 1'b0}},
		'{OP_INSERT, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    7'd3, 1'b0}},
		'{OP_INSERT, 32'hffff_ffff, 1'b0, '0},
		'{OP_INSERT, 32'h0000_0001, 1'b0, '0},
		'{OP_INSERT, 32'h0000_0000, 1'b0, '0},
		'{OP_INSERT, 32'h7fff_ffff, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, ST_OK,    7'd6, 1'b0}},
		'{OP_REMOVE, 32'h1234_5678, 1'b1, '{32'h7fff_ffff, ST_OK,    7'd5, 1'b0}},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK,    7'd0, 1'b1}},
		'{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0, 1'b1}},
		'{OP_INSERT, 32'h8000_0000, 1'b0, '0},
		'{OP_INSERT, 32'h8000_0001, 1'b0, '0},
		'{OP_INSERT, 32'haaaa_aaaa, 1'b0, '0},
		'{OP_INSERT, 32'h5555_5555, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0}
	};

	// share of inserts per phase, swinging between filling up and draining
	localparam int INSERT_BIAS [9] = '{95, 60, 10, 90, 40, 97, 5, 70, 50};

	localparam logic [DATA_W-1:0] EDGE_VALUES [6] = '{
		32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000,
		32'h8000_0001, 32'h0000_0000, 32'hffff_ffff
	};

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic signed [DATA_W-1:0] mirror_entries [$];	// largest first
	queue_result_t            awaited_results [$];
	int unsigned              mismatches;
	int unsigned              idle_cycles;
	bit                       calm;
	bit                       hold_off_wanted;

	function automatic queue_result_t sorted_queue_step(opcode_t op, logic [DATA_W-1:0] value);
		queue_result_t outcome;
		int            slot;
		outcome.removed_value = '0;
		outcome.status        = ST_OK;
		if (op == OP_INSERT) begin
			if (mirror_entries.size() >= QUEUE_DEPTH) begin
				outcome.status = ST_FULL;
			end else begin
				// goes behind strictly greater entries, ahead of equal ones
				slot = 0;
				while (slot < mirror_entries.size() && mirror_entries[slot] > $signed(value))
					slot++;
				mirror_entries.insert(slot, $signed(value));
			end
		end else if (mirror_entries.size() == 0) begin
			outcome.status = ST_EMPTY;
		end else begin
			outcome.removed_value = mirror_entries.pop_front();
		end
		outcome.entry_count = CNT_W'(mirror_entries.size());
		outcome.is_empty    = (mirror_entries.size() == 0);
		return outcome;
	endfunction

	task automatic offer_request(opcode_t op, logic [DATA_W-1:0] value, logic typed,
		queue_result_t typed_result);
		queue_result_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.value  <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = sorted_queue_step(op, value);
		awaited_results.push_back(typed ? typed_result : predicted);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int                n;
		int                insert_pct;
		opcode_t           op;
		logic [DATA_W-1:0] value;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.opcode   <= 1'b0;
		req_ch.value    <= '0;
		mismatches      = 0;
		calm            = 1'b0;
		hold_off_wanted = 1'b0;
		insert_pct      = 50;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_COUNT; n++)
			offer_request(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].value,
				DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].result);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0)
				insert_pct = INSERT_BIAS[(n / PHASE_ITEMS) % 9];
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			if (n == HOLD_OFF_AT)
				hold_off_wanted = 1'b1;
			op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: value = $urandom;
				// narrow band so equal values pile up
				5, 6, 7: value = $urandom_range(0, 15) - 8;
				default: value = EDGE_VALUES[$urandom_range(0, 5)];
			endcase
			offer_request(op, value, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// result side back-pressure, with one long hold-off so the core stalls on a waiting result
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_wanted) begin
				hold_off_wanted = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		queue_result_t want;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;

		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: removed %0d status %0d count %0d empty %0b",
						$signed(rsp_ch.removed_value), rsp_ch.status,
						rsp_ch.entry_count, rsp_ch.is_empty);
			end else begin
				want = awaited_results.pop_front();
				if (rsp_ch.removed_value !== want.removed_value ||
					rsp_ch.status !== want.status ||
					rsp_ch.entry_count !== want.entry_count ||
					rsp_ch.is_empty !== want.is_empty) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"mismatch: expected removed %0d status %0d count %0d empty %0b,",
							" got removed %0d status %0d count %0d empty %0b"},
							$signed(want.removed_value), want.status, want.entry_count,
							want.is_empty, $signed(rsp_ch.removed_value), rsp_ch.status,
							rsp_ch.entry_count, rsp_ch.is_empty);
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		wait (idle_cycles >= STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_tb.sv
